/* design/pkf_pkg.sv */
`timescale 1ns / 1ps
// Package for the port rule packet filter: field widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package pkf_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned DIDX_W   = 6;
  localparam int unsigned HOOK_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned VERD_W   = 2;
  localparam int unsigned STAT_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INBOUND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OUTBOUND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PROXY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INERT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd5;

  localparam logic [HOOK_W-1:0] HOOK_PRE  = 2'd0;
  localparam logic [HOOK_W-1:0] HOOK_FWD  = 2'd1;
  localparam logic [HOOK_W-1:0] HOOK_POST = 2'd2;

  localparam logic [VERD_W-1:0] VERD_ACCEPT = 2'd0;
  localparam logic [VERD_W-1:0] VERD_DROP   = 2'd1;
  localparam logic [VERD_W-1:0] VERD_PROXY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_RULE = 2'd2;

  localparam logic [ADDR_W-1:0] PROXY_RESET = 32'h8301_0101;

  typedef struct packed {
    logic capture;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* design/pkf_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces of the port rule packet filter.
// Depends on pkf_pkg for the field widths.
interface pkf_in_if import pkf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KIND_W-1:0]   rule_kind;
  logic [PORT_W-1:0]   rule_port;
  logic [DIDX_W-1:0]   delete_index;
  logic [HOOK_W-1:0]   hook_point;
  logic [PORT_W-1:0]   source_port;
  logic [PORT_W-1:0]   dest_port;
  logic [ADDR_W-1:0]   dest_address;

  modport source(output valid, action, rule_kind, rule_port, delete_index, hook_point,
                 source_port, dest_port, dest_address, input ready);
  modport sink(input valid, action, rule_kind, rule_port, delete_index, hook_point,
               source_port, dest_port, dest_address, output ready);
endinterface

interface pkf_out_if import pkf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [ADDR_W-1:0] out_dest_address;
  logic [PORT_W-1:0] out_dest_port;
  logic [STAT_W-1:0] status;

  modport source(output valid, verdict, out_dest_address, out_dest_port, status,
                 input ready);
  modport sink(input valid, verdict, out_dest_address, out_dest_port, status,
               output ready);
endinterface

/* design/port_rule_packet_filter.sv */
`timescale 1ns / 1ps
// Port rule packet filter top level. One request is handled at a time.
// Add: the result goes to the output register once it has room. Delete and classify
// scan the table RAM one entry per cycle (delete stops at its rule), then wait for
// room in the output register. The next request can be taken once its result is
// registered.
// Reset clears the fill count and sets the proxy to 131.1.1.1; the RAM is not cleared.
module port_rule_packet_filter import pkf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  pkf_in_if.sink            in_i,
  pkf_out_if.source         out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  pkf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .sts_i     (sts),
    .in_ready_o(in_ready),
    .cmd_o     (cmd)
  );

  pkf_datapath #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (in_i.action),
    .rule_kind_i       (in_i.rule_kind),
    .rule_port_i       (in_i.rule_port),
    .delete_index_i    (in_i.delete_index),
    .hook_point_i      (in_i.hook_point),
    .source_port_i     (in_i.source_port),
    .dest_port_i       (in_i.dest_port),
    .dest_address_i    (in_i.dest_address),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .verdict_o         (out_o.verdict),
    .out_dest_address_o(out_o.out_dest_address),
    .out_dest_port_o   (out_o.out_dest_port),
    .status_o          (out_o.status)
  );

  assign in_i.ready = in_ready;

endmodule

/* design/pkf_ram.sv */
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pkf_ram #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pkf_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the port rule packet filter: sequences
// capture, table scan and result hand-off. Depends on pkf_pkg.
module pkf_ctrl import pkf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = sts_i.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The result waits here until the output register has room.
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted while the output register is occupied");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start processing");

endmodule

/* design/pkf_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the port rule packet filter: request registers, rule table RAM,
// scan counters, match logic, proxy register and output register.
// Depends on pkf_pkg and pkf_ram.
module pkf_datapath import pkf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [ADDR_W-1:0]   cfg_wdata_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [KIND_W-1:0]   rule_kind_i,
  input  logic [PORT_W-1:0]   rule_port_i,
  input  logic [DIDX_W-1:0]   delete_index_i,
  input  logic [HOOK_W-1:0]   hook_point_i,
  input  logic [PORT_W-1:0]   source_port_i,
  input  logic [PORT_W-1:0]   dest_port_i,
  input  logic [ADDR_W-1:0]   dest_address_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [VERD_W-1:0]   verdict_o,
  output logic [ADDR_W-1:0]   out_dest_address_o,
  output logic [PORT_W-1:0]   out_dest_port_o,
  output logic [STAT_W-1:0]   status_o
);

  localparam int unsigned IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(RULE_SLOTS + 1);
  localparam int unsigned LW = (CW > DIDX_W) ? CW : DIDX_W;
  localparam int unsigned EW = KIND_W + PORT_W;

  // Request registers.
  logic [ACTION_W-1:0] act_q;
  logic [KIND_W-1:0]   kind_q;
  logic [PORT_W-1:0]   rport_q;
  logic [DIDX_W-1:0]   didx_q;
  logic [HOOK_W-1:0]   hook_q;
  logic [PORT_W-1:0]   sport_q;
  logic [PORT_W-1:0]   dport_q;
  logic [ADDR_W-1:0]   daddr_q;

  logic [ADDR_W-1:0] proxy_q;
  logic [CW-1:0]     fill_q;
  logic [CW-1:0]     ptr_q;
  logic [CW-1:0]     live_q;
  logic [IW-1:0]     rd_idx_q;
  logic              rd_vld_q;
  logic              hit_a_q;
  logic              hit_b_q;
  logic              del_done_q;

  logic              out_valid_q;
  logic [VERD_W-1:0] verdict_q, verdict_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [PORT_W-1:0] oport_q, oport_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic [EW-1:0]     rdata;
  logic [KIND_W-1:0] rd_kind;
  logic [PORT_W-1:0] rd_port;
  logic [PORT_W-1:0] key_port;
  logic [KIND_W-1:0] kind_a, kind_b;
  logic              en_a, en_b;
  logic              is_delete, is_classify;
  logic              live_entry, del_hit, issue, table_full, add_we;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [KIND_W-1:0] add_kind;

  assign rd_kind = rdata[EW-1:PORT_W];
  assign rd_port = rdata[PORT_W-1:0];

  // Hook point picks the key port and the kinds that can match. At
  // pre-routing the proxy kind goes on hit_a and takes priority over hit_b.
  always_comb begin
    key_port = dport_q;
    kind_a   = KIND_FORWARD;
    kind_b   = KIND_INBOUND;
    en_a     = 1'b0;
    en_b     = 1'b0;
    case (hook_q)
      HOOK_PRE: begin
        key_port = sport_q;
        kind_a   = KIND_PROXY;
        en_a     = 1'b1;
        en_b     = 1'b1;
      end
      HOOK_FWD: begin
        kind_a = KIND_FORWARD;
        en_a   = 1'b1;
      end
      HOOK_POST: begin
        kind_a = KIND_OUTBOUND;
        en_a   = 1'b1;
      end
      default: begin
        en_a = 1'b0;
      end
    endcase
  end

  assign is_delete   = (act_q == ACT_DELETE);
  assign is_classify = (act_q == ACT_CLASSIFY);
  assign live_entry  = rd_vld_q && (rd_kind != KIND_REMOVED);
  assign del_hit     = cmd_i.scan && is_delete && live_entry && !del_done_q &&
                       (LW'(live_q) == LW'(didx_q));
  assign issue       = cmd_i.scan && (ptr_q != fill_q) && !del_done_q && !del_hit;
  assign table_full  = (fill_q == CW'(RULE_SLOTS));
  assign add_we      = cmd_i.emit && (act_q == ACT_ADD) && !table_full;
  assign add_kind    = (kind_q > KIND_INERT) ? KIND_INERT : kind_q;

  assign ram_we    = del_hit || add_we;
  assign ram_waddr = del_hit ? rd_idx_q : fill_q[IW-1:0];
  assign ram_wdata = del_hit ? {KIND_REMOVED, rd_port} : {add_kind, rport_q};

  pkf_ram #(
    .WIDTH(EW),
    .DEPTH(RULE_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_q[IW-1:0]),
    .rdata_o(rdata)
  );

  assign sts_o.need_scan = (action_i == ACT_DELETE) || (action_i == ACT_CLASSIFY);
  assign sts_o.scan_done = del_done_q || (!rd_vld_q && (ptr_q == fill_q));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      kind_q  <= rule_kind_i;
      rport_q <= rule_port_i;
      didx_q  <= delete_index_i;
      hook_q  <= hook_point_i;
      sport_q <= source_port_i;
      dport_q <= dest_port_i;
      daddr_q <= dest_address_i;
    end
    if (issue) begin
      rd_idx_q <= ptr_q[IW-1:0];
    end
  end

  // Scan state: reads stream one entry a cycle, each checked in the cycle after its read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      live_q     <= '0;
      rd_vld_q   <= 1'b0;
      hit_a_q    <= 1'b0;
      hit_b_q    <= 1'b0;
      del_done_q <= 1'b0;
    end else if (cmd_i.capture) begin
      ptr_q      <= '0;
      live_q     <= '0;
      rd_vld_q   <= 1'b0;
      hit_a_q    <= 1'b0;
      hit_b_q    <= 1'b0;
      del_done_q <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_q <= issue;
      if (issue) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (live_entry && !del_done_q) begin
        live_q <= live_q + CW'(1);
      end
      if (del_hit) begin
        del_done_q <= 1'b1;
      end
      if (is_classify && rd_vld_q && (rd_port == key_port)) begin
        if (en_a && (rd_kind == kind_a)) begin
          hit_a_q <= 1'b1;
        end
        if (en_b && (rd_kind == kind_b)) begin
          hit_b_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      proxy_q <= PROXY_RESET;
    end else begin
      if (add_we) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cfg_we_i) begin
        proxy_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    verdict_d = VERD_ACCEPT;
    oaddr_d   = '0;
    oport_d   = '0;
    status_d  = STAT_OK;
    case (act_q)
      ACT_ADD: begin
        status_d = table_full ? STAT_FULL : STAT_OK;
      end
      ACT_DELETE: begin
        status_d = del_done_q ? STAT_OK : STAT_NO_RULE;
      end
      ACT_CLASSIFY: begin
        oaddr_d = daddr_q;
        oport_d = dport_q;
        if (hit_a_q) begin
          if (hook_q == HOOK_PRE) begin
            verdict_d = VERD_PROXY;
            oaddr_d   = proxy_q;
            oport_d   = sport_q;
          end else begin
            verdict_d = VERD_DROP;
          end
        end else if (hit_b_q) begin
          verdict_d = VERD_DROP;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      verdict_q <= verdict_d;
      oaddr_q   <= oaddr_d;
      oport_q   <= oport_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign verdict_o          = verdict_q;
  assign out_dest_address_o = oaddr_q;
  assign out_dest_port_o    = oport_q;
  assign status_o           = status_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(RULE_SLOTS))
    else $error("fill count beyond table size");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= fill_q)
    else $error("scan pointer passed the fill count");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CW'(rd_idx_q) < fill_q))
    else $error("scan checked an entry that was never written");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for port_rule_packet_filter: directed and random add,
// delete and classify requests, checked against a behavioral copy of the rule table.
// Depends on pkf_pkg, the pkf_in_if and pkf_out_if interfaces, and the design.
module testbench;
  import pkf_pkg::*;

  localparam int unsigned RULE_SLOTS  = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned CHUNKS      = 11;
  localparam int unsigned CHUNK_ITEMS = 100;
  localparam int unsigned POOL_SIZE   = 12;
  localparam int unsigned IDLE_PCT    = 21;

  // Codes that the package leaves unnamed; the block must treat them as inert.
  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
  localparam logic [HOOK_W-1:0]   HOOK_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0]   KIND_TOP    = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KIND_W-1:0]   rule_kind;
    logic [PORT_W-1:0]   rule_port;
    logic [DIDX_W-1:0]   delete_index;
    logic [HOOK_W-1:0]   hook_point;
    logic [PORT_W-1:0]   source_port;
    logic [PORT_W-1:0]   dest_port;
    logic [ADDR_W-1:0]   dest_address;
  } request_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [ADDR_W-1:0] out_dest_address;
    logic [PORT_W-1:0] out_dest_port;
    logic [STAT_W-1:0] status;
  } result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i = '0;

  pkf_in_if  req_if();
  pkf_out_if res_if();

  port_rule_packet_filter #(.RULE_SLOTS(RULE_SLOTS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Behavioral copy of the rule table and the proxy address register.
  logic [KIND_W-1:0] rule_kind_tbl [RULE_SLOTS];
  logic [PORT_W-1:0] rule_port_tbl [RULE_SLOTS];
  int unsigned       rules_filled;
  logic [ADDR_W-1:0] proxy_addr_model;

  request_t          request_queue[$];
  result_t           expected_results[$];
  request_t          held_request;
  logic [PORT_W-1:0] port_pool [POOL_SIZE];
  int unsigned       req_idle_pct;
  int unsigned       res_idle_pct;
  int unsigned       mismatches;
  int unsigned       stall_cycles;
  logic              req_fire;
  result_t           want;

  function automatic logic rule_hit(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] port);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < rules_filled; i++)
      if (rule_kind_tbl[i] == kind && rule_port_tbl[i] == port) hit = 1'b1;
    return hit;
  endfunction

  function automatic result_t filter_predict(request_t rq);
    result_t     rs;
    int unsigned live;
    logic        found;
    rs = '0;
    case (rq.action)
      ACT_ADD: begin
        if (rules_filled >= RULE_SLOTS) begin
          rs.status = STAT_FULL;
        end else begin
          rule_kind_tbl[rules_filled] = (rq.rule_kind > KIND_INERT) ? KIND_INERT : rq.rule_kind;
          rule_port_tbl[rules_filled] = rq.rule_port;
          rules_filled++;
        end
      end
      ACT_DELETE: begin
        live  = 0;
        found = 1'b0;
        if (rq.delete_index < rules_filled) begin
          for (int i = 0; i < rules_filled; i++) begin
            if (!found && rule_kind_tbl[i] != KIND_REMOVED) begin
              if (live == rq.delete_index) begin
                rule_kind_tbl[i] = KIND_REMOVED;
                found = 1'b1;
              end
              live++;
            end
          end
        end
        rs.status = found ? STAT_OK : STAT_NO_RULE;
      end
      ACT_CLASSIFY: begin
        rs.verdict          = VERD_ACCEPT;
        rs.out_dest_address = rq.dest_address;
        rs.out_dest_port    = rq.dest_port;
        case (rq.hook_point)
          HOOK_PRE: begin
            // A proxy rule on the source port wins over an inbound drop.
            if (rule_hit(KIND_PROXY, rq.source_port)) begin
              rs.verdict          = VERD_PROXY;
              rs.out_dest_address = proxy_addr_model;
              rs.out_dest_port    = rq.source_port;
            end else if (rule_hit(KIND_INBOUND, rq.source_port)) begin
              rs.verdict = VERD_DROP;
            end
          end
          HOOK_FWD: begin
            if (rule_hit(KIND_FORWARD, rq.dest_port)) rs.verdict = VERD_DROP;
          end
          HOOK_POST: begin
            if (rule_hit(KIND_OUTBOUND, rq.dest_port)) rs.verdict = VERD_DROP;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic request_t req_of(logic [ACTION_W-1:0] action, logic [KIND_W-1:0] kind,
                                      logic [PORT_W-1:0] rport, logic [DIDX_W-1:0] didx,
                                      logic [HOOK_W-1:0] hook, logic [PORT_W-1:0] sport,
                                      logic [PORT_W-1:0] dport, logic [ADDR_W-1:0] addr);
    request_t rq;
    rq.action       = action;
    rq.rule_kind    = kind;
    rq.rule_port    = rport;
    rq.delete_index = didx;
    rq.hook_point   = hook;
    rq.source_port  = sport;
    rq.dest_port    = dport;
    rq.dest_address = addr;
    return rq;
  endfunction

  // Random request; the fields that the action does not use stay random.
  function automatic request_t random_request(int unsigned live);
    request_t    rq;
    logic [95:0] bits;
    int unsigned pick;
    int unsigned hook_pick;
    bits = {$urandom, $urandom, $urandom};
    rq   = request_t'(bits[$bits(request_t)-1:0]);
    pick = $urandom_range(0, 99);
    if (pick < 9) begin
      rq.action = ACT_ADD;
      if ($urandom_range(0, 99) < 85)
        rq.rule_kind = KIND_W'($urandom_range(KIND_INBOUND, KIND_PROXY));
      else
        rq.rule_kind = KIND_W'($urandom_range(KIND_INERT, KIND_TOP));
      if ($urandom_range(0, 99) < 85) rq.rule_port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 14) begin
      rq.action = ACT_DELETE;
      if ($urandom_range(0, 99) < 70)
        rq.delete_index = DIDX_W'($urandom_range(0, (live > 0) ? live - 1 : 0));
    end else if (pick < 97) begin
      rq.action = ACT_CLASSIFY;
      hook_pick = $urandom_range(0, 99);
      if (hook_pick < 32)      rq.hook_point = HOOK_PRE;
      else if (hook_pick < 64) rq.hook_point = HOOK_FWD;
      else if (hook_pick < 96) rq.hook_point = HOOK_POST;
      else                     rq.hook_point = HOOK_UNUSED;
      if ($urandom_range(0, 99) < 75) rq.source_port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 99) < 75) rq.dest_port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      rq.action = ACT_UNUSED;
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic wait_for_drain();
    while (request_queue.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver: holds a request until it is taken, then predicts its result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) expected_results.push_back(filter_predict(held_request));
      if (!req_if.valid || req_fire) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
          held_request          = request_queue.pop_front();
          req_if.valid         <= 1'b1;
          req_if.action        <= held_request.action;
          req_if.rule_kind     <= held_request.rule_kind;
          req_if.rule_port     <= held_request.rule_port;
          req_if.delete_index  <= held_request.delete_index;
          req_if.hook_point    <= held_request.hook_point;
          req_if.source_port   <= held_request.source_port;
          req_if.dest_port     <= held_request.dest_port;
          req_if.dest_address  <= held_request.dest_address;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (res_if.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", res_if.verdict, want.verdict));
          if (res_if.out_dest_address !== want.out_dest_address)
            report_mismatch($sformatf("out_dest_address %h, expected %h",
                                      res_if.out_dest_address, want.out_dest_address));
          if (res_if.out_dest_port !== want.out_dest_port)
            report_mismatch($sformatf("out_dest_port %0d, expected %0d",
                                      res_if.out_dest_port, want.out_dest_port));
          if (res_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", res_if.status, want.status));
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= res_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] proxy_val;
    int unsigned       live;
    req_if.valid        = 1'b0;
    req_if.action       = '0;
    req_if.rule_kind    = '0;
    req_if.rule_port    = '0;
    req_if.delete_index = '0;
    req_if.hook_point   = '0;
    req_if.source_port  = '0;
    req_if.dest_port    = '0;
    req_if.dest_address = '0;
    res_if.ready        = 1'b0;
    rules_filled        = 0;
    proxy_addr_model    = PROXY_RESET;
    mismatches          = 0;
    stall_cycles        = 0;
    req_idle_pct        = IDLE_PCT;
    res_idle_pct        = IDLE_PCT;
    port_pool[0] = 16'd0;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'd80;
    port_pool[3] = 16'd443;
    port_pool[4] = 16'd22;
    port_pool[5] = 16'd8080;
    port_pool[6] = 16'd1;
    port_pool[7] = 16'h8000;
    for (int i = 8; i < POOL_SIZE; i++) port_pool[i] = PORT_W'($urandom);

    // Directed requests under the reset proxy address.
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'd0, 16'd7,
                                   32'h0A00_0001));
    request_queue.push_back(req_of(ACT_DELETE, '0, '0, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_INBOUND, 16'd0, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_PROXY, 16'hFFFF, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_FORWARD, 16'd80, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_OUTBOUND, 16'd443, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_TOP, 16'd22, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_INERT, 16'd22, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_ADD, KIND_INBOUND, 16'hFFFF, '0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'd0, 16'd99,
                                   32'h0000_0000));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'hFFFF, 16'd1234,
                                   32'hFFFF_FFFF));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_FWD, 16'd5, 16'd80,
                                   32'hC0A8_0001));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_POST, 16'd5, 16'd80,
                                   32'hC0A8_0002));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_POST, 16'd5, 16'd443,
                                   32'hC0A8_0003));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_UNUSED, 16'd0, 16'd443,
                                   32'h1234_5678));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'd22, 16'd22,
                                   32'h0101_0101));
    request_queue.push_back(req_of(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1));
    request_queue.push_back(req_of(ACT_DELETE, '0, '0, '1, HOOK_PRE, '0, '0, '0));
    // Removing the proxy rule lets the inbound drop on the same port take effect.
    request_queue.push_back(req_of(ACT_DELETE, '0, '0, 6'd1, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'hFFFF, 16'd4321,
                                   32'hFFFF_FFFF));
    // Index below the fill count but past the live rules.
    request_queue.push_back(req_of(ACT_DELETE, '0, '0, 6'd6, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_DELETE, '0, '0, 6'd0, HOOK_PRE, '0, '0, '0));
    request_queue.push_back(req_of(ACT_CLASSIFY, '0, '0, '0, HOOK_PRE, 16'd0, 16'd99,
                                   32'h0A00_0002));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_for_drain();

    for (int c = 0; c < CHUNKS; c++) begin
      case (c % 4)
        0:       proxy_val = '0;
        1:       proxy_val = '1;
        default: proxy_val = $urandom;
      endcase
      if (c == CHUNKS - 1) proxy_val = PROXY_RESET;
      // The block is idle here, so the register can be rewritten.
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= proxy_val;
      @(posedge clk_i);
      cfg_we_i         <= 1'b0;
      proxy_addr_model  = proxy_val;

      req_idle_pct = (c == 5) ? 0 : IDLE_PCT;
      res_idle_pct = (c == 5) ? 0 : IDLE_PCT;
      live = 0;
      for (int i = 0; i < rules_filled; i++)
        if (rule_kind_tbl[i] != KIND_REMOVED) live++;
      repeat (CHUNK_ITEMS) request_queue.push_back(random_request(live));
      wait_for_drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
